>>> rtl/core/pcm_linear_resampler_top_macros.svh
// Assertion helpers shared by the resampler RTL.
// Simulation builds get the checks; synthesis builds see empty bodies.
`ifndef PCM_LINEAR_RESAMPLER_TOP_MACROS_SVH
`define PCM_LINEAR_RESAMPLER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define PCMR_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("pcmr assertion failed");
// Condition must never be seen at a clock edge outside reset.
`define PCMR_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("pcmr forbidden condition seen");
`else
`define PCMR_ASSERT(lbl, clk, rst_n, prop)
`define PCMR_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

>>> rtl/core/pcmr_pkg.sv
package pcmr_pkg;

	// Rates and limits.
	localparam int unsigned DEF_OUTPUT_RATE = 16000;
	localparam int unsigned RATE_MIN = 2000;
	localparam int unsigned RATE_MAX = 96000;
	localparam int unsigned RATE_RESET = 16000;
	localparam int unsigned MAX_RESULTS = 8;

	// Field widths.
	localparam int RATE_W = 17;
	localparam int BYTE_W = 8;
	localparam int SAMPLE_W = 16;
	// Quotient bits of the shared divider; covers any sample magnitude.
	localparam int QUO_W = 16;

	// Entries in the command queue between front and back.
	localparam int QUEUE_DEPTH = 2;

	// Input selector code.
	localparam logic FUNC_START = 1'b1;

	typedef enum logic {
		CMD_SAMPLE = 1'b0,
		CMD_START  = 1'b1
	} cmd_kind_t;

	// Command handed from the front to the back.
	typedef struct packed {
		cmd_kind_t             kind;
		logic [SAMPLE_W-1:0]   sample;
	} cmd_t;

endpackage

>>> rtl/core/pcm_linear_resampler_top.sv
// Linear-interpolation sample rate converter from a configurable source rate to
// OUTPUT_RATE (16 kHz by default). Input beats carry one byte of little-endian
// 16-bit mono PCM; s_tuser high marks a start beat that clears all stream state,
// and s_tlast is accepted but has no effect. A low byte is only held in the
// front. A completed sample is queued (two entries) and either stored, passed
// through, or expanded into one or more output beats; m_tlast marks the last
// beat produced by a sample. The back end takes a sample from the queue, sends
// a pass-through sample to the output register, and steps each interpolated
// output through multiply, load, the reciprocal-multiply divider by the output
// rate, and the output register. A sample holds the back end until all of its
// outputs, up to eight, are out; output stalls add to that and fill the queue,
// which then stalls input. Writing source_rate starts, once the back end is
// idle, a split of the rate into whole and fractional steps on the same
// divider; queued samples wait until it is done. Out-of-range rates saturate.
module pcm_linear_resampler_top #(
	parameter int unsigned OUTPUT_RATE = pcmr_pkg::DEF_OUTPUT_RATE
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [pcmr_pkg::RATE_W-1:0]   cfg_wdata,     // source_rate
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [pcmr_pkg::BYTE_W-1:0]   s_tdata,       // [7:0] pcm_byte
	input  logic                          s_tuser,       // [0] func
	input  logic                          s_tlast,       // frame_last
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [pcmr_pkg::SAMPLE_W-1:0] m_tdata,       // [15:0] out_sample
	output logic                          m_tlast        // run_last
);
	import pcmr_pkg::*;

	logic frm_unused;
	logic push;
	cmd_t push_cmd;
	logic q_full;
	logic pop;
	cmd_t q_head;
	logic q_empty;

	// Frame marks do not change the sample stream.
	assign frm_unused = s_tlast;

	pcmr_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_func (s_tuser),
		.in_byte (s_tdata),
		.push    (push),
		.push_cmd(push_cmd),
		.q_full  (q_full)
	);

	pcmr_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.full    (q_full),
		.pop     (pop),
		.head    (q_head),
		.empty   (q_empty)
	);

	pcmr_back #(
		.OUTPUT_RATE(OUTPUT_RATE)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_sample(m_tdata),
		.out_last  (m_tlast)
	);

endmodule

>>> rtl/core/pcmr_front.sv
module pcmr_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        in_func,
	input  logic [pcmr_pkg::BYTE_W-1:0] in_byte,
	output logic                        push,
	output pcmr_pkg::cmd_t              push_cmd,
	input  logic                        q_full
);
	import pcmr_pkg::*;

	logic              accept;
	logic              is_start;
	logic [BYTE_W-1:0] low_q;
	logic              have_low_q;

	// Every beat can be taken while the queue has room for what it may produce.
	assign in_ready = !q_full;
	assign accept = in_valid && in_ready;
	assign is_start = (in_func == FUNC_START);

	// A start beat or the high byte of a sample produces a command.
	assign push = accept && (is_start || have_low_q);

	always_comb begin
		push_cmd.kind = is_start ? CMD_START : CMD_SAMPLE;
		push_cmd.sample = {in_byte, low_q};
	end

	// Byte pairing state; a start beat drops a pending low byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_low_q <= 1'b0;
			low_q <= '0;
		end else if (accept) begin
			if (is_start) begin
				have_low_q <= 1'b0;
			end else begin
				have_low_q <= !have_low_q;
				if (!have_low_q) begin
					low_q <= in_byte;
				end
			end
		end
	end

endmodule

>>> rtl/core/pcmr_queue.sv
`include "pcm_linear_resampler_top_macros.svh"

module pcmr_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  pcmr_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output pcmr_pkg::cmd_t head,
	output logic           empty
);
	import pcmr_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head = entry_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	`PCMR_NEVER(a_pop_when_empty, clk, arst_n, pop && empty)
	`PCMR_NEVER(a_push_when_full, clk, arst_n, push && full && !pop)
	`PCMR_ASSERT(a_count_bound, clk, arst_n, cnt_q <= CNT_W'(QUEUE_DEPTH))

endmodule

>>> rtl/core/pcmr_div.sv
module pcmr_div #(
	parameter int unsigned OUTPUT_RATE = pcmr_pkg::DEF_OUTPUT_RATE
) (
	input  logic                                                clk,
	input  logic                                                arst_n,
	input  logic                                                start,
	input  logic [$clog2(OUTPUT_RATE+1)+pcmr_pkg::QUO_W-1:0]    dividend,
	output logic                                                done,
	output logic [pcmr_pkg::QUO_W-1:0]                          quotient,
	output logic [$clog2(OUTPUT_RATE+1)-1:0]                    remainder
);
	import pcmr_pkg::*;

	localparam int OR_W = $clog2(OUTPUT_RATE + 1);
	localparam int NUM_W = OR_W + QUO_W;
	// Rounded-up reciprocal scaled so that the quotient is exact for every dividend.
	localparam int SH = NUM_W + $clog2(OUTPUT_RATE);
	localparam int REC_W = NUM_W + 1;
	localparam int PRD_W = NUM_W + REC_W;
	localparam logic [63:0] RECIP_FULL =
		((64'd1 << SH) + 64'(OUTPUT_RATE) - 64'd1) / 64'(OUTPUT_RATE);
	localparam logic [REC_W-1:0] RECIP = RECIP_FULL[REC_W-1:0];

	logic [NUM_W-1:0] num_s1;
	logic [NUM_W-1:0] num_s2;
	logic [QUO_W-1:0] quo_s2;
	logic             vld_s1;
	logic             vld_s2;
	logic             done_q;
	logic [QUO_W-1:0] quo_q;
	logic [OR_W-1:0]  rem_q;
	logic [PRD_W-1:0] prod;
	logic [NUM_W-1:0] quo_x_rate;
	logic [NUM_W-1:0] rem_full;

	// Quotient by reciprocal multiplication, remainder by multiply and subtract.
	assign prod = PRD_W'(num_s1) * PRD_W'(RECIP);
	assign quo_x_rate = NUM_W'(quo_s2) * NUM_W'(OUTPUT_RATE);
	assign rem_full = num_s2 - quo_x_rate;

	assign done = done_q;
	assign quotient = quo_q;
	assign remainder = rem_q;

	// Stage valid flags; start moves through vld_s1 and vld_s2 to done.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			done_q <= vld_s2;
		end
	end

	// Dividend, quotient and remainder pipeline.
	always_ff @(posedge clk) begin
		if (start) begin
			num_s1 <= dividend;
		end
		if (vld_s1) begin
			num_s2 <= num_s1;
			quo_s2 <= prod[SH +: QUO_W];
		end
		if (vld_s2) begin
			quo_q <= quo_s2;
			rem_q <= rem_full[OR_W-1:0];
		end
	end

endmodule

>>> rtl/core/pcmr_back.sv
`include "pcm_linear_resampler_top_macros.svh"

module pcmr_back #(
	parameter int unsigned OUTPUT_RATE = pcmr_pkg::DEF_OUTPUT_RATE
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [pcmr_pkg::RATE_W-1:0]   cfg_wdata,
	input  logic                          q_empty,
	input  pcmr_pkg::cmd_t                q_head,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [pcmr_pkg::SAMPLE_W-1:0] out_sample,
	output logic                          out_last
);
	import pcmr_pkg::*;

	localparam int PH_W = $clog2(OUTPUT_RATE);
	localparam int OR_W = $clog2(OUTPUT_RATE + 1);
	localparam int NUM_W = OR_W + QUO_W;
	localparam int unsigned ADV_MAX = (OUTPUT_RATE - 1 + RATE_MAX) / OUTPUT_RATE;
	localparam int ADV_W = $clog2(ADV_MAX + 1);
	localparam int SKIP_W = (ADV_MAX > 1) ? $clog2(ADV_MAX) : 1;
	localparam int unsigned NEED = (OUTPUT_RATE + MAX_RESULTS - 1) / MAX_RESULTS;
	localparam int unsigned RATE_LO = (NEED > RATE_MIN) ? NEED : RATE_MIN;
	localparam int unsigned RST_RATE = (RATE_RESET < RATE_LO) ? RATE_LO :
		((RATE_RESET > RATE_MAX) ? RATE_MAX : RATE_RESET);
	localparam int unsigned RST_INT = RST_RATE / OUTPUT_RATE;
	localparam int unsigned RST_FRAC = RST_RATE % OUTPUT_RATE;
	localparam int DIFF_W = SAMPLE_W + 1;
	localparam int PROD_W = DIFF_W + PH_W + 1;
	localparam int SUM_W = OR_W + QUO_W + 2;
	localparam logic signed [SUM_W-1:0] OR_S = SUM_W'(OUTPUT_RATE);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_RDIV = 6'b000010,
		ST_MUL  = 6'b000100,
		ST_LOAD = 6'b001000,
		ST_DIV  = 6'b010000,
		ST_EMIT = 6'b100000
	} state_t;

	state_t                      state_q;
	logic [RATE_W-1:0]           rate_q;
	logic [RATE_W-1:0]           rate_clamped;
	logic                        cfg_pend_q;
	logic [ADV_W-1:0]            rate_int_q;
	logic [PH_W-1:0]             rate_frac_q;
	logic signed [SAMPLE_W-1:0]  prev_q;
	logic                        have_prev_q;
	logic [PH_W-1:0]             phase_q;
	logic [SKIP_W-1:0]           skip_q;
	logic signed [SAMPLE_W-1:0]  b_q;
	logic                        pass_q;
	logic                        neg_q;
	logic signed [PROD_W-1:0]    prod_s1;
	logic [SAMPLE_W-1:0]         res_q;
	logic                        out_valid_q;
	logic [SAMPLE_W-1:0]         out_sample_q;
	logic                        out_last_q;

	logic                        pass_thru;
	logic signed [DIFF_W-1:0]    diff;
	logic signed [PROD_W-1:0]    prod;
	logic signed [SUM_W-1:0]     num;
	logic [SUM_W-1:0]            mag;
	logic [PH_W:0]               ph_sum;
	logic                        ph_carry;
	logic [PH_W-1:0]             ph_next;
	logic [ADV_W-1:0]            adv;
	logic                        out_load;
	logic                        div_start;
	logic [NUM_W-1:0]            div_dividend;
	logic                        div_done;
	logic [QUO_W-1:0]            div_quo;
	logic [OR_W-1:0]             div_rem;

	// Saturate a written rate into the supported range.
	always_comb begin
		if (cfg_wdata < RATE_W'(RATE_LO)) begin
			rate_clamped = RATE_W'(RATE_LO);
		end else if (cfg_wdata > RATE_W'(RATE_MAX)) begin
			rate_clamped = RATE_W'(RATE_MAX);
		end else begin
			rate_clamped = cfg_wdata;
		end
	end

	// A sample goes straight out when rates match and nothing is in progress.
	assign pass_thru = (rate_q == RATE_W'(OUTPUT_RATE)) && (phase_q == '0) && (skip_q == '0);

	// Slope times phase; the left sample times the output rate is added next cycle.
	assign diff = DIFF_W'(b_q) - DIFF_W'(prev_q);
	assign prod = PROD_W'(diff) * PROD_W'($signed({1'b0, phase_q}));
	assign num = SUM_W'(prev_q) * OR_S + SUM_W'(prod_s1);
	assign mag = num[SUM_W-1] ? SUM_W'(-num) : SUM_W'(num);

	// Phase advance split into whole source steps and the fractional part.
	assign ph_sum = {1'b0, phase_q} + {1'b0, rate_frac_q};
	assign ph_carry = (ph_sum >= (PH_W + 1)'(OUTPUT_RATE));
	assign ph_next = ph_carry ? PH_W'(ph_sum - (PH_W + 1)'(OUTPUT_RATE)) : ph_sum[PH_W-1:0];
	assign adv = rate_int_q + ADV_W'(ph_carry);

	assign pop = (state_q == ST_IDLE) && !cfg_pend_q && !q_empty;
	assign out_load = (state_q == ST_EMIT) && (!out_valid_q || out_ready);

	// The divider serves both the rate split and the interpolation.
	assign div_start = ((state_q == ST_IDLE) && cfg_pend_q) || (state_q == ST_LOAD);
	assign div_dividend = (state_q == ST_LOAD) ? mag[NUM_W-1:0]
		: {{(NUM_W - RATE_W){1'b0}}, rate_q};

	pcmr_div #(
		.OUTPUT_RATE(OUTPUT_RATE)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.done     (div_done),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	assign out_valid = out_valid_q;
	assign out_sample = out_sample_q;
	assign out_last = out_last_q;

	// Sequencer, stream state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rate_q <= RATE_W'(RST_RATE);
			cfg_pend_q <= 1'b0;
			rate_int_q <= ADV_W'(RST_INT);
			rate_frac_q <= PH_W'(RST_FRAC);
			prev_q <= '0;
			have_prev_q <= 1'b0;
			phase_q <= '0;
			skip_q <= '0;
			b_q <= '0;
			pass_q <= 1'b0;
			neg_q <= 1'b0;
			prod_s1 <= '0;
			res_q <= '0;
			out_valid_q <= 1'b0;
			out_sample_q <= '0;
			out_last_q <= 1'b0;
		end else begin
			// A new rate is split once the sequencer is back in idle.
			if (cfg_we) begin
				rate_q <= rate_clamped;
				cfg_pend_q <= 1'b1;
			end else if ((state_q == ST_IDLE) && cfg_pend_q) begin
				cfg_pend_q <= 1'b0;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
				out_sample_q <= res_q;
				out_last_q <= pass_q || (adv != '0);
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (cfg_pend_q) begin
						state_q <= ST_RDIV;
					end else if (!q_empty) begin
						if (q_head.kind == CMD_START) begin
							prev_q <= '0;
							have_prev_q <= 1'b0;
							phase_q <= '0;
							skip_q <= '0;
						end else if (!have_prev_q) begin
							if (pass_thru) begin
								res_q <= q_head.sample;
								pass_q <= 1'b1;
								state_q <= ST_EMIT;
							end else begin
								prev_q <= $signed(q_head.sample);
								have_prev_q <= 1'b1;
							end
						end else if (skip_q != '0) begin
							skip_q <= skip_q - 1'b1;
							prev_q <= $signed(q_head.sample);
						end else begin
							b_q <= $signed(q_head.sample);
							pass_q <= 1'b0;
							state_q <= ST_MUL;
						end
					end
				end
				ST_RDIV: begin
					if (div_done) begin
						rate_int_q <= ADV_W'(div_quo);
						rate_frac_q <= PH_W'(div_rem);
						state_q <= ST_IDLE;
					end
				end
				ST_MUL: begin
					prod_s1 <= prod;
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					neg_q <= num[SUM_W-1];
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						res_q <= neg_q ? SAMPLE_W'(-div_quo) : div_quo;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_load) begin
						if (pass_q) begin
							state_q <= ST_IDLE;
						end else begin
							phase_q <= ph_next;
							if (adv != '0) begin
								skip_q <= SKIP_W'(adv - 1'b1);
								prev_q <= b_q;
								state_q <= ST_IDLE;
							end else begin
								state_q <= ST_MUL;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`PCMR_ASSERT(a_phase_range, clk, arst_n, {1'b0, phase_q} < (PH_W + 1)'(OUTPUT_RATE))
	`PCMR_ASSERT(a_skip_needs_prev, clk, arst_n, (skip_q != '0) |-> have_prev_q)
	`PCMR_ASSERT(a_div_done_state, clk, arst_n, div_done |-> (state_q == ST_DIV || state_q == ST_RDIV))

endmodule

>>> tb/tb_pcm_linear_resampler_top.sv
module tb_pcm_linear_resampler_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int OUT_RATE = int'(pcmr_pkg::DEF_OUTPUT_RATE);
	localparam int MAX_RES = int'(pcmr_pkg::MAX_RESULTS);
	localparam int RATE_TOP = int'(pcmr_pkg::RATE_MAX);
	localparam int RATE_BITS = pcmr_pkg::RATE_W;
	// Lowest usable rate: the hard floor, raised if a sample could need more than MAX_RES outputs.
	localparam int RATE_NEED = (OUT_RATE + MAX_RES - 1) / MAX_RES;
	localparam int RATE_FLOOR = (RATE_NEED > int'(pcmr_pkg::RATE_MIN)) ?
		RATE_NEED : int'(pcmr_pkg::RATE_MIN);
	localparam int IDLE_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;
	localparam int HOLD_AT_BEAT = 41;
	localparam int SETTLE_CYCLES = 100;

	typedef struct packed {
		logic       func;
		logic [7:0] data;
		logic       frame_last;
	} pcm_beat_t;

	typedef struct packed {
		logic signed [15:0] sample;
		logic               last;
	} out_beat_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_we = 1'b0;
	logic [pcmr_pkg::RATE_W-1:0]   cfg_wdata = '0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [pcmr_pkg::BYTE_W-1:0]   s_tdata = '0;    // [7:0] pcm_byte
	logic                          s_tuser = 1'b0;  // [0] func
	logic                          s_tlast = 1'b0;  // frame_last
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [pcmr_pkg::SAMPLE_W-1:0] m_tdata;         // [15:0] out_sample
	logic                          m_tlast;         // run_last

	pcm_linear_resampler_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	// Shared bookkeeping.
	pcm_beat_t pending_beats[$];
	out_beat_t expected_samples[$];
	int        errors = 0;
	int        beats_in = 0;
	int        results_seen = 0;
	int        in_stall_cycles = 0;
	int        rate_writes = 0;
	int        idle_cycles = 0;
	int        hold_left = 0;
	bit        hold_done = 1'b0;
	wire       steady = (beats_in >= 90) && (beats_in < 130);

	// Predicted stream state of the resampler.
	logic [pcmr_pkg::RATE_W-1:0] src_rate = RATE_BITS'(pcmr_pkg::RATE_RESET);
	logic [7:0]                  held_lo = '0;
	bit                          have_lo = 1'b0;
	logic signed [15:0]          prev_smp = '0;
	bit                          have_prev = 1'b0;
	int                          phase_acc = 0;
	int                          skip_left = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void report_error(input string msg);
		errors++;
		if (errors <= 10)
			$display("[%0t] error: %s", $realtime, msg);
	endfunction

	// Advance the predicted state by one accepted input beat and queue the outputs it causes.
	task automatic take_pcm_byte(input logic func, input logic [7:0] byt);
		int                 rate;
		int                 adv;
		int                 n;
		longint             num;
		longint             quo;
		logic signed [15:0] smp;
		bit                 done;
		out_beat_t          ob;

		rate = int'(src_rate);
		if (rate < RATE_FLOOR)
			rate = RATE_FLOOR;
		if (rate > RATE_TOP)
			rate = RATE_TOP;

		if (func == pcmr_pkg::FUNC_START) begin
			held_lo = '0;
			have_lo = 1'b0;
			prev_smp = '0;
			have_prev = 1'b0;
			phase_acc = 0;
			skip_left = 0;
			return;
		end
		if (!have_lo) begin
			held_lo = byt;
			have_lo = 1'b1;
			return;
		end
		have_lo = 1'b0;
		smp = {byt, held_lo};

		// First sample of a stream: passed through at the output rate, otherwise kept.
		if (!have_prev) begin
			if (rate == OUT_RATE && phase_acc == 0 && skip_left == 0) begin
				ob.sample = smp;
				ob.last = 1'b1;
				expected_samples.push_back(ob);
			end else begin
				prev_smp = smp;
				have_prev = 1'b1;
			end
			return;
		end

		// Downsampling: samples between interpolation points are only consumed.
		if (skip_left > 0) begin
			skip_left--;
			prev_smp = smp;
			return;
		end

		n = 0;
		done = 1'b0;
		while (!done) begin
			num = longint'(prev_smp) * longint'(OUT_RATE - phase_acc) +
				longint'(smp) * longint'(phase_acc);
			quo = num / longint'(OUT_RATE);
			phase_acc += rate;
			adv = phase_acc / OUT_RATE;
			phase_acc = phase_acc % OUT_RATE;
			n++;
			if (adv > 0)
				skip_left = adv - 1;
			done = (adv > 0) || (n == MAX_RES);
			ob.sample = quo[15:0];
			ob.last = done;
			expected_samples.push_back(ob);
		end
		prev_smp = smp;
	endtask

	// Sender: offers queued beats, idling at random outside the steady window.
	always @(posedge clk or negedge arst_n) begin
		pcm_beat_t bt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (pending_beats.size() > 0 && (steady || $urandom_range(99) >= 25)) begin
				bt = pending_beats.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= bt.func;
				s_tdata <= bt.data;
				s_tlast <= bt.frame_last;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, one long hold-off to back the block up, and a steady window.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_done && beats_in >= HOLD_AT_BEAT) begin
			m_tready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else begin
			m_tready <= steady || ($urandom_range(99) >= 25);
		end
	end

	// Monitor: predicts on every accepted input beat and checks every accepted output beat.
	always @(posedge clk) begin
		out_beat_t ob;
		if (arst_n) begin
			if (s_tvalid && !s_tready)
				in_stall_cycles <= in_stall_cycles + 1;
			if (s_tvalid && s_tready) begin
				beats_in <= beats_in + 1;
				take_pcm_byte(s_tuser, s_tdata);
			end
			if (m_tvalid && m_tready) begin
				results_seen <= results_seen + 1;
				if (expected_samples.size() == 0) begin
					report_error($sformatf("unexpected output beat sample=%0d last=%0b",
						$signed(m_tdata), m_tlast));
				end else begin
					ob = expected_samples.pop_front();
					if (m_tdata !== ob.sample)
						report_error($sformatf("sample expected %0d got %0d",
							ob.sample, $signed(m_tdata)));
					if (m_tlast !== ob.last)
						report_error($sformatf("last flag expected %0b got %0b (sample %0d)",
							ob.last, m_tlast, ob.sample));
				end
			end
		end
	end

	// Watchdog: ends the run if no beat moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: no beat accepted for %0d cycles", IDLE_LIMIT);
			$display("CHECK FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic void push_byte(input logic [7:0] d, input logic fl);
		pcm_beat_t bt;
		bt.func = ~pcmr_pkg::FUNC_START;
		bt.data = d;
		bt.frame_last = fl;
		pending_beats.push_back(bt);
	endfunction

	function automatic void push_start(input logic [7:0] d, input logic fl);
		pcm_beat_t bt;
		bt.func = pcmr_pkg::FUNC_START;
		bt.data = d;
		bt.frame_last = fl;
		pending_beats.push_back(bt);
	endfunction

	function automatic void push_sample(input logic [15:0] s, input logic fl);
		push_byte(s[7:0], 1'b0);
		push_byte(s[15:8], fl);
	endfunction

	// Mostly PCM bytes with random content; a few start beats and frame marks mixed in.
	function automatic void queue_random_bytes(input int count);
		pcm_beat_t bt;
		for (int i = 0; i < count; i++) begin
			bt.func = ($urandom_range(15) == 0) ? pcmr_pkg::FUNC_START : ~pcmr_pkg::FUNC_START;
			case ($urandom_range(7))
				0: bt.data = 8'h00;
				1: bt.data = 8'hFF;
				2: bt.data = 8'h80;
				3: bt.data = 8'h7F;
				default: bt.data = 8'($urandom);
			endcase
			bt.frame_last = ($urandom_range(7) == 0);
			pending_beats.push_back(bt);
		end
	endfunction

	// Wait until every queued beat is taken and every predicted output has arrived,
	// then give a sample that produced no output time to leave the pipeline.
	task automatic drain();
		do
			@(negedge clk);
		while (pending_beats.size() > 0 || s_tvalid || expected_samples.size() > 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_rate(input logic [pcmr_pkg::RATE_W-1:0] r);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= r;
		src_rate = r;
		rate_writes++;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [pcmr_pkg::RATE_W-1:0] rand_rates[8];
		rand_rates = '{17'd44100, 17'd8000, 17'h1FFFF, 17'd0,
			17'd16000, 17'd22050, 17'd1999, 17'd48000};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Reset rate: pass-through of extreme samples, frame marks and a start mid-sample.
		push_start(8'hA5, 1'b0);
		push_sample(16'h8000, 1'b0);
		push_sample(16'h7FFF, 1'b1);
		push_sample(16'hFFFF, 1'b0);
		push_byte(8'h34, 1'b1);
		push_byte(8'h12, 1'b0);
		push_byte(8'h55, 1'b0);
		push_start(8'h5A, 1'b1);
		push_sample(16'h0001, 1'b0);
		drain();

		// Lowest rate: full-scale swings give the longest interpolation runs.
		write_rate(17'd2000);
		push_sample(16'h8000, 1'b0);
		push_sample(16'h7FFF, 1'b0);
		push_sample(16'h8000, 1'b0);
		drain();

		// Highest rate: long skips, left unfinished so they carry into the next setting.
		write_rate(17'd96000);
		push_start(8'h00, 1'b0);
		push_sample(16'h8000, 1'b0);
		push_sample(16'h7FFF, 1'b1);
		push_sample(16'h1234, 1'b0);
		push_sample(16'hEDCB, 1'b0);
		drain();

		// Random content under a sweep of rates, in range and out of range.
		foreach (rand_rates[i]) begin
			write_rate(rand_rates[i]);
			queue_random_bytes(12);
			drain();
		end

		if (expected_samples.size() > 0)
			report_error($sformatf("%0d expected outputs never arrived",
				expected_samples.size()));

		$display("Run: %0d input beats, %0d output beats checked, %0d rate writes.",
			beats_in, results_seen, rate_writes);
		$display("Input backpressure seen on %0d cycles; %0d errors.", in_stall_cycles, errors);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/pcmr_pkg.sv
rtl/core/pcmr_front.sv
rtl/core/pcmr_queue.sv
rtl/core/pcmr_div.sv
rtl/core/pcmr_back.sv
rtl/core/pcm_linear_resampler_top.sv
tb/tb_pcm_linear_resampler_top.sv
